@@ rtl/wav_stream_parser_defines.svh @@
// Assertion macros shared by the WAV stream parser RTL.
`ifndef WAV_STREAM_PARSER_DEFINES_SVH
`define WAV_STREAM_PARSER_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define WSP_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define WSP_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/wsp_pkg.sv @@
// Types and constants of the WAV stream parser.
package wsp_pkg;

	// parser phases, one-hot
	typedef enum logic [6:0] {
		PH_HEADER = 7'b0000001,
		PH_FORM   = 7'b0000010,
		PH_FMT    = 7'b0000100,
		PH_SKIP   = 7'b0001000,
		PH_DATA   = 7'b0010000,
		PH_DONE   = 7'b0100000,
		PH_HALT   = 7'b1000000
	} phase_t;

	// event codes on the result side
	typedef enum logic [2:0] {
		EV_FRAME      = 3'd0,
		EV_DATA_START = 3'd1,
		EV_BAD_FORMAT = 3'd2,
		EV_TOO_LARGE  = 3'd3,
		EV_DATA_END   = 3'd4,
		EV_EARLY_EOF  = 3'd5
	} event_t;

	// input word kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_EOF  = 1'b1;

	// register map
	localparam logic REG_MAX_CHUNK = 1'b0;

	// chunk ids, little-endian character order
	localparam logic [31:0] ID_RIFF = 32'h4646_4952;
	localparam logic [31:0] ID_WAVE = 32'h4556_4157;
	localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
	localparam logic [31:0] ID_DATA = 32'h6174_6164;

	localparam logic [15:0] FMT_TAG_PCM     = 16'd1;
	localparam logic [31:0] MAX_CHUNK_RESET = 32'd1000000000;

	// byte positions inside headers and the fmt body
	localparam logic [3:0] HDR_ID_BYTES = 4'd4;
	localparam logic [3:0] HDR_LAST     = 4'd7;
	localparam logic [3:0] FORM_LAST    = 4'd3;
	localparam logic [3:0] FMT_TAG_END  = 4'd2;
	localparam logic [3:0] FMT_CH_END   = 4'd4;
	localparam logic [3:0] FMT_RATE_END = 4'd8;
	localparam logic [3:0] FMT_BITS_BEG = 4'd14;
	localparam logic [3:0] FMT_LAST     = 4'd15;
	localparam logic [31:0] FORM_BYTES  = 32'd4;
	localparam logic [31:0] FMT_BYTES   = 32'd16;
	localparam logic [15:0] BITS_U8     = 16'd8;
	localparam logic [15:0] CH_MONO     = 16'd1;

	// one result word
	typedef struct packed {
		event_t      ev;
		logic [15:0] left;
		logic [15:0] right;
		logic [31:0] rate;
		logic [15:0] channels;
		logic [15:0] bits;
		logic        last;
	} result_t;

endpackage

@@ rtl/wav_stream_parser.sv @@
// WAV stream parser: RIFF/WAVE byte stream in, events and PCM frames out.
//
// Usage:
//   Slave stream: one word per file byte. tdata carries the byte, tuser
//   marks end of file (1) instead of a byte. Master stream: one word per
//   event; tuser is the event code, tdata the frame and fmt values, tlast
//   marks the final word caused by one input word. The APB port holds the
//   largest chunk size that may be skipped (address 0).
//   Throughput: one input word per cycle. Each accepted word is decoded in
//   the cycle it is taken; its zero, one or two results enter a four-entry
//   result queue, and the first one is offered from the next cycle on,
//   behind any older results still queued. The result queue sets the
//   rate: input is taken while at least two entries are free, so a word
//   stream that makes at most one result per word runs at full rate.
//   Reset: parser returns to chunk header, all stores clear, the queue
//   empties and the size limit returns to 1000000000.
//   Receiver stall: results wait in the queue; once fewer than two
//   entries are free, s_tready drops until results are taken.
module wav_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic        s_tuser,   // [0] kind
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [15:0] left_sample, [31:16] right_sample,
	                               // [63:32] rate_hz, [79:64] channel_total,
	                               // [95:80] sample_bits
	output logic [2:0]  m_tuser,   // [2:0] event_res
	output logic        m_tlast,   // last_of_run
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import wsp_pkg::*;

	`include "wav_stream_parser_defines.svh"

	// parser state
	phase_t      phase_q, phase_d;
	logic [3:0]  field_count_q, field_count_d;
	logic [31:0] chunk_id_q, chunk_id_d;
	logic [31:0] chunk_length_q, chunk_length_d;
	logic [15:0] format_tag_q, format_tag_d;
	logic [15:0] channel_q, channel_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] bits_q, bits_d;
	logic [31:0] skip_q, skip_d;
	logic [31:0] data_rem_q, data_rem_d;
	logic [7:0]  low_byte_q, low_byte_d;
	logic [15:0] left_hold_q, left_hold_d;
	logic [1:0]  frame_pos_q, frame_pos_d;
	logic [31:0] max_chunk_q;

	// result queue
	result_t     fifo_q [4];
	logic [1:0]  wr_ptr_q, rd_ptr_q;
	logic [2:0]  count_q;

	logic        in_acc, out_acc;
	result_t     res0, res1;
	logic [1:0]  n_res;
	logic [7:0]  b;
	logic [3:0]  fc_inc;
	logic [31:0] len_new, skip_dec, data_dec;
	logic [15:0] s8, s16;
	logic        mono;
	logic        wr_en;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign b       = s_tdata;
	assign fc_inc  = field_count_q + 4'd1;
	assign len_new = {b, chunk_length_q[31:8]};
	assign skip_dec = skip_q - 32'd1;
	assign data_dec = data_rem_q - 32'd1;
	assign s8      = {~b[7], ~b[7], b[6:0], 7'd0};
	assign s16     = {b, low_byte_q};
	assign mono    = (channel_q == CH_MONO);

	// APB: single register, no wait states
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr == REG_MAX_CHUNK);
	assign prdata = (paddr == REG_MAX_CHUNK) ? max_chunk_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chunk_q <= MAX_CHUNK_RESET;
		end else if (wr_en) begin
			max_chunk_q <= pwdata;
		end
	end

	// decode one byte: next state and up to two results
	always_comb begin
		phase_d        = phase_q;
		field_count_d  = field_count_q;
		chunk_id_d     = chunk_id_q;
		chunk_length_d = chunk_length_q;
		format_tag_d   = format_tag_q;
		channel_d      = channel_q;
		rate_d         = rate_q;
		bits_d         = bits_q;
		skip_d         = skip_q;
		data_rem_d     = data_rem_q;
		low_byte_d     = low_byte_q;
		left_hold_d    = left_hold_q;
		frame_pos_d    = frame_pos_q;
		res0           = '0;
		res1           = '0;
		n_res          = 2'd0;

		if (s_tuser == KIND_EOF) begin
			if (phase_q != PH_DONE && phase_q != PH_HALT) begin
				res0.ev = EV_EARLY_EOF;
				n_res   = 2'd1;
				phase_d = PH_DONE;
			end
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					if (field_count_q < HDR_ID_BYTES) begin
						chunk_id_d = {b, chunk_id_q[31:8]};
					end else begin
						chunk_length_d = len_new;
					end
					field_count_d = fc_inc;
					if (field_count_q == HDR_LAST) begin
						field_count_d = '0;
						if (chunk_id_q == ID_DATA) begin
							data_rem_d    = len_new;
							frame_pos_d   = '0;
							res0.ev       = EV_DATA_START;
							res0.rate     = rate_q;
							res0.channels = channel_q;
							res0.bits     = bits_q;
							n_res         = 2'd1;
							if (len_new == '0) begin
								res1.ev = EV_DATA_END;
								n_res   = 2'd2;
								phase_d = PH_DONE;
							end else begin
								phase_d = PH_DATA;
							end
						end else if (chunk_id_q == ID_RIFF) begin
							phase_d = PH_FORM;
						end else if (chunk_id_q == ID_FMT) begin
							phase_d = PH_FMT;
						end else if (len_new > max_chunk_q) begin
							res0.ev = EV_TOO_LARGE;
							n_res   = 2'd1;
							phase_d = PH_HALT;
						end else begin
							skip_d  = len_new;
							phase_d = (len_new == '0) ? PH_HEADER : PH_SKIP;
						end
					end
				end
				PH_FORM: begin
					chunk_id_d    = {b, chunk_id_q[31:8]};
					field_count_d = fc_inc;
					if (field_count_q == FORM_LAST) begin
						field_count_d = '0;
						if ({b, chunk_id_q[31:8]} == ID_WAVE) begin
							phase_d = PH_HEADER;
						end else if (chunk_length_q > max_chunk_q) begin
							res0.ev = EV_TOO_LARGE;
							n_res   = 2'd1;
							phase_d = PH_HALT;
						end else if (chunk_length_q > FORM_BYTES) begin
							skip_d  = chunk_length_q - FORM_BYTES;
							phase_d = PH_SKIP;
						end else begin
							skip_d  = '0;
							phase_d = PH_HEADER;
						end
					end
				end
				PH_FMT: begin
					if (field_count_q < FMT_TAG_END) begin
						format_tag_d = {b, format_tag_q[15:8]};
					end else if (field_count_q < FMT_CH_END) begin
						channel_d = {b, channel_q[15:8]};
					end else if (field_count_q < FMT_RATE_END) begin
						rate_d = {b, rate_q[31:8]};
					end else if (field_count_q >= FMT_BITS_BEG) begin
						bits_d = {b, bits_q[15:8]};
					end
					field_count_d = fc_inc;
					if (field_count_q == FMT_LAST) begin
						field_count_d = '0;
						if (format_tag_q != FMT_TAG_PCM) begin
							res0.ev = EV_BAD_FORMAT;
							n_res   = 2'd1;
							phase_d = PH_HALT;
						end else if (chunk_length_q > FMT_BYTES) begin
							skip_d  = chunk_length_q - FMT_BYTES;
							phase_d = PH_SKIP;
						end else begin
							skip_d  = '0;
							phase_d = PH_HEADER;
						end
					end
				end
				PH_SKIP: begin
					if (skip_q != '0) begin
						skip_d = skip_dec;
					end
					if (skip_q <= 32'd1) begin
						phase_d = PH_HEADER;
					end
				end
				PH_DATA: begin
					data_rem_d = data_dec;
					if (bits_q == BITS_U8) begin
						if (frame_pos_q == 2'd0 && !mono) begin
							left_hold_d = s8;
							frame_pos_d = 2'd1;
						end else if (frame_pos_q == 2'd0) begin
							res0.ev    = EV_FRAME;
							res0.left  = s8;
							res0.right = s8;
							n_res      = 2'd1;
						end else begin
							res0.ev     = EV_FRAME;
							res0.left   = left_hold_q;
							res0.right  = s8;
							n_res       = 2'd1;
							frame_pos_d = 2'd0;
						end
					end else if (!frame_pos_q[0]) begin
						low_byte_d  = b;
						frame_pos_d = frame_pos_q + 2'd1;
					end else if (frame_pos_q == 2'd1 && !mono) begin
						left_hold_d = s16;
						frame_pos_d = 2'd2;
					end else if (frame_pos_q == 2'd1) begin
						res0.ev     = EV_FRAME;
						res0.left   = s16;
						res0.right  = s16;
						n_res       = 2'd1;
						frame_pos_d = 2'd0;
					end else begin
						res0.ev     = EV_FRAME;
						res0.left   = left_hold_q;
						res0.right  = s16;
						n_res       = 2'd1;
						frame_pos_d = 2'd0;
					end
					// close the data chunk on its final byte
					if (data_dec == '0) begin
						phase_d = PH_DONE;
						if (n_res == 2'd1) begin
							res1.ev = EV_DATA_END;
							n_res   = 2'd2;
						end else begin
							res0.ev = EV_DATA_END;
							n_res   = 2'd1;
						end
					end
				end
				PH_DONE, PH_HALT: begin
					phase_d = phase_q;
				end
				default: begin
					phase_d = PH_HALT;
				end
			endcase
		end

		// mark the final result of this word
		if (n_res == 2'd2) begin
			res1.last = 1'b1;
		end else begin
			res0.last = 1'b1;
		end
	end

	// advance parser state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			field_count_q  <= '0;
			chunk_id_q     <= '0;
			chunk_length_q <= '0;
			format_tag_q   <= '0;
			channel_q      <= '0;
			rate_q         <= '0;
			bits_q         <= '0;
			skip_q         <= '0;
			data_rem_q     <= '0;
			low_byte_q     <= '0;
			left_hold_q    <= '0;
			frame_pos_q    <= '0;
		end else if (in_acc) begin
			phase_q        <= phase_d;
			field_count_q  <= field_count_d;
			chunk_id_q     <= chunk_id_d;
			chunk_length_q <= chunk_length_d;
			format_tag_q   <= format_tag_d;
			channel_q      <= channel_d;
			rate_q         <= rate_d;
			bits_q         <= bits_d;
			skip_q         <= skip_d;
			data_rem_q     <= data_rem_d;
			low_byte_q     <= low_byte_d;
			left_hold_q    <= left_hold_d;
			frame_pos_q    <= frame_pos_d;
		end
	end

	// result queue: push up to two words, pop one
	always_ff @(posedge clk) begin
		if (in_acc && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (in_acc && n_res == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_acc) begin
				wr_ptr_q <= wr_ptr_q + n_res;
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + (in_acc ? {1'b0, n_res} : 3'd0) - {2'b0, out_acc};
		end
	end

	assign s_tready = (count_q <= 3'd2);
	assign m_tvalid = (count_q != 3'd0);
	assign m_tdata  = {fifo_q[rd_ptr_q].bits, fifo_q[rd_ptr_q].channels,
	                   fifo_q[rd_ptr_q].rate, fifo_q[rd_ptr_q].right,
	                   fifo_q[rd_ptr_q].left};
	assign m_tuser  = fifo_q[rd_ptr_q].ev;
	assign m_tlast  = fifo_q[rd_ptr_q].last;

	// checks
	`WSP_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= 3'd4,
		"result queue overflow")
	`WSP_ASSERT_NEXT(a_halt_sticky, clk, arst_n, phase_q == PH_HALT,
		phase_q == PH_HALT, "parser left halt without reset")
	`WSP_ASSERT_NEXT(a_done_sticky, clk, arst_n, phase_q == PH_DONE,
		phase_q == PH_DONE, "parser left done without reset")
	`WSP_ASSERT_NEXT(a_data_close, clk, arst_n,
		in_acc && phase_q == PH_DATA && data_rem_q == 32'd1,
		phase_q == PH_DONE, "data chunk not closed on its final byte")
	`WSP_ASSERT_NEXT(a_push_visible, clk, arst_n, in_acc && n_res != 2'd0,
		m_tvalid, "pushed result not offered")

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for wav_stream_parser with a predicted result stream.
module tb_top;
	import wsp_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int          IDLE_PCT      = 26;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          ITEM_TARGET   = 1700;
	localparam logic [31:0] FORM_LIST     = 32'h5453_494C;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] byte_value
	logic        s_tuser;   // [0] kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;   // [15:0] left_sample, [31:16] right_sample,
	                        // [63:32] rate_hz, [79:64] channel_total,
	                        // [95:80] sample_bits
	logic [2:0]  m_tuser;   // [2:0] event_res
	logic        m_tlast;   // last_of_run
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [0:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// parser state as the predictor sees it
	phase_t      parse_phase   = PH_HEADER;
	logic [4:0]  hdr_pos       = '0;
	logic [31:0] chunk_tag     = '0;
	logic [31:0] chunk_size    = '0;
	logic [15:0] tag_seen      = '0;
	logic [15:0] channels_seen = '0;
	logic [31:0] rate_seen     = '0;
	logic [15:0] bits_seen     = '0;
	logic [31:0] skip_count    = '0;
	logic [31:0] data_count    = '0;
	logic [7:0]  low_held      = '0;
	logic [15:0] left_held     = '0;
	logic [1:0]  frame_pos     = '0;
	logic [31:0] size_limit    = MAX_CHUNK_RESET;

	result_t     parsed_events[$];

	int          err_count       = 0;
	int          words_sent      = 0;
	int          results_checked = 0;
	int          frames_checked  = 0;
	int unsigned cycle_count     = 0;
	int          ending_pick;
	string       ending_name     = "none";
	logic        stalls_on       = 1'b1;

	wav_stream_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic result_t make_event(event_t ev, logic [15:0] l, logic [15:0] r,
			logic [31:0] rate, logic [15:0] ch, logic [15:0] bits);
		result_t x;
		x.ev       = ev;
		x.left     = l;
		x.right    = r;
		x.rate     = rate;
		x.channels = ch;
		x.bits     = bits;
		x.last     = 1'b0;
		return x;
	endfunction

	task automatic begin_skip(input logic [31:0] n);
		hdr_pos     = '0;
		skip_count  = n;
		parse_phase = (n == 0) ? PH_HEADER : PH_SKIP;
	endtask

	// Advance the parser by one accepted word and queue the results it causes.
	task automatic parse_word(input logic kind, input logic [7:0] b);
		result_t     batch[$];
		logic [15:0] smp;
		logic        mono;
		int          wide;
		if (parse_phase == PH_DONE || parse_phase == PH_HALT)
			return;
		if (kind == KIND_EOF) begin
			batch.push_back(make_event(EV_EARLY_EOF, '0, '0, '0, '0, '0));
			parse_phase = PH_DONE;
		end else begin
			case (parse_phase)
			PH_HEADER: begin
				if (hdr_pos < HDR_ID_BYTES)
					chunk_tag = {b, chunk_tag[31:8]};
				else
					chunk_size = {b, chunk_size[31:8]};
				hdr_pos = hdr_pos + 5'd1;
				if (hdr_pos == 5'd8) begin
					hdr_pos = '0;
					if (chunk_tag == ID_DATA) begin
						data_count = chunk_size;
						frame_pos  = '0;
						batch.push_back(make_event(EV_DATA_START, '0, '0, rate_seen,
							channels_seen, bits_seen));
						if (data_count == 0) begin
							batch.push_back(make_event(EV_DATA_END, '0, '0, '0, '0, '0));
							parse_phase = PH_DONE;
						end else begin
							parse_phase = PH_DATA;
						end
					end else if (chunk_tag == ID_RIFF) begin
						parse_phase = PH_FORM;
					end else if (chunk_tag == ID_FMT) begin
						parse_phase = PH_FMT;
					end else if (chunk_size > size_limit) begin
						batch.push_back(make_event(EV_TOO_LARGE, '0, '0, '0, '0, '0));
						parse_phase = PH_HALT;
					end else begin
						begin_skip(chunk_size);
					end
				end
			end
			PH_FORM: begin
				chunk_tag = {b, chunk_tag[31:8]};
				hdr_pos   = hdr_pos + 5'd1;
				if (hdr_pos == 5'd4) begin
					hdr_pos = '0;
					if (chunk_tag == ID_WAVE) begin
						parse_phase = PH_HEADER;
					end else if (chunk_size > size_limit) begin
						batch.push_back(make_event(EV_TOO_LARGE, '0, '0, '0, '0, '0));
						parse_phase = PH_HALT;
					end else begin
						begin_skip(chunk_size > FORM_BYTES ? chunk_size - FORM_BYTES : 32'd0);
					end
				end
			end
			PH_FMT: begin
				if (hdr_pos < FMT_TAG_END)
					tag_seen = {b, tag_seen[15:8]};
				else if (hdr_pos < FMT_CH_END)
					channels_seen = {b, channels_seen[15:8]};
				else if (hdr_pos < FMT_RATE_END)
					rate_seen = {b, rate_seen[31:8]};
				else if (hdr_pos >= FMT_BITS_BEG)
					bits_seen = {b, bits_seen[15:8]};
				hdr_pos = hdr_pos + 5'd1;
				if (hdr_pos == FMT_BYTES) begin
					hdr_pos = '0;
					if (tag_seen != FMT_TAG_PCM) begin
						batch.push_back(make_event(EV_BAD_FORMAT, '0, '0, '0, '0, '0));
						parse_phase = PH_HALT;
					end else begin
						// the size limit never applies to the fmt tail
						begin_skip(chunk_size > FMT_BYTES ? chunk_size - FMT_BYTES : 32'd0);
					end
				end
			end
			PH_SKIP: begin
				if (skip_count != 0)
					skip_count = skip_count - 1;
				if (skip_count == 0)
					parse_phase = PH_HEADER;
			end
			PH_DATA: begin
				mono       = (channels_seen == CH_MONO);
				data_count = data_count - 1;
				if (bits_seen == BITS_U8) begin
					wide = (int'(b) - 128) * 128;
					smp  = wide[15:0];
					if (frame_pos == 0 && !mono) begin
						left_held = smp;
						frame_pos = 2'd1;
					end else if (frame_pos == 0) begin
						batch.push_back(make_event(EV_FRAME, smp, smp, '0, '0, '0));
					end else begin
						batch.push_back(make_event(EV_FRAME, left_held, smp, '0, '0, '0));
						frame_pos = 2'd0;
					end
				end else if (frame_pos[0] == 1'b0) begin
					low_held  = b;
					frame_pos = frame_pos + 2'd1;
				end else begin
					smp = {b, low_held};
					if (frame_pos == 2'd1 && !mono) begin
						left_held = smp;
						frame_pos = 2'd2;
					end else if (frame_pos == 2'd1) begin
						batch.push_back(make_event(EV_FRAME, smp, smp, '0, '0, '0));
						frame_pos = 2'd0;
					end else begin
						batch.push_back(make_event(EV_FRAME, left_held, smp, '0, '0, '0));
						frame_pos = 2'd0;
					end
				end
				// a partial frame at the end is dropped
				if (data_count == 0) begin
					batch.push_back(make_event(EV_DATA_END, '0, '0, '0, '0, '0));
					parse_phase = PH_DONE;
				end
			end
			default: ;
			endcase
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i])
			parsed_events.push_back(batch[i]);
	endtask

	// ---------------------------------------------------------------- result check

	always @(posedge clk) m_tready <= !stalls_on || ($urandom_range(0, 99) >= 34);

	// Compare each accepted result word with the oldest expectation.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (parsed_events.size() == 0) begin
				err_count++;
				$error("unexpected result word: event_res %0d", m_tuser);
			end else begin
				want = parsed_events.pop_front();
				results_checked++;
				if (want.ev == EV_FRAME)
					frames_checked++;
				if (m_tuser !== want.ev) begin
					err_count++;
					$error("event_res: expected %0d, actual %0d", want.ev, m_tuser);
				end
				if (m_tdata[15:0] !== want.left) begin
					err_count++;
					$error("left_sample: expected %0d, actual %0d",
						$signed(want.left), $signed(m_tdata[15:0]));
				end
				if (m_tdata[31:16] !== want.right) begin
					err_count++;
					$error("right_sample: expected %0d, actual %0d",
						$signed(want.right), $signed(m_tdata[31:16]));
				end
				if (m_tdata[63:32] !== want.rate) begin
					err_count++;
					$error("rate_hz: expected %0d, actual %0d", want.rate, m_tdata[63:32]);
				end
				if (m_tdata[79:64] !== want.channels) begin
					err_count++;
					$error("channel_total: expected %0d, actual %0d",
						want.channels, m_tdata[79:64]);
				end
				if (m_tdata[95:80] !== want.bits) begin
					err_count++;
					$error("sample_bits: expected %0d, actual %0d", want.bits, m_tdata[95:80]);
				end
				if (m_tlast !== want.last) begin
					err_count++;
					$error("last_of_run: expected %0d, actual %0d", want.last, m_tlast);
				end
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	// Offer one word, wait for the handshake, then maybe idle.
	task automatic send_word(input logic kind, input logic [7:0] b);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		parse_word(kind, b);
		words_sent++;
		if (stalls_on && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic send_u16(input logic [15:0] v);
		send_word(KIND_BYTE, v[7:0]);
		send_word(KIND_BYTE, v[15:8]);
	endtask

	task automatic send_u32(input logic [31:0] v);
		for (int i = 0; i < 4; i++)
			send_word(KIND_BYTE, v[8 * i +: 8]);
	endtask

	task automatic send_fill(input logic [31:0] n);
		repeat (n) send_word(KIND_BYTE, 8'($urandom));
	endtask

	task automatic send_head(input logic [31:0] id, input logic [31:0] len);
		send_u32(id);
		send_u32(len);
	endtask

	task automatic send_eof();
		send_word(KIND_EOF, 8'($urandom));
	endtask

	task automatic send_fmt(input logic [15:0] tag, input logic [15:0] ch,
			input logic [31:0] rate, input logic [15:0] bits, input logic [31:0] len);
		send_head(ID_FMT, len);
		send_u16(tag);
		send_u16(ch);
		send_u32(rate);
		send_u32($urandom);
		send_u16(16'($urandom));
		send_u16(bits);
		send_fill(len > FMT_BYTES ? len - FMT_BYTES : 32'd0);
	endtask

	task automatic send_riff(input logic [31:0] form, input logic [31:0] len);
		send_head(ID_RIFF, len);
		send_u32(form);
		if (form != ID_WAVE)
			send_fill(len > FORM_BYTES ? len - FORM_BYTES : 32'd0);
	endtask

	task automatic send_other(input logic [31:0] id, input logic [31:0] len);
		send_head(id, len);
		send_fill(len);
	endtask

	// Pick an id the parser does not know: a one-bit miss of a known id, or noise.
	function automatic logic [31:0] stray_id();
		logic [31:0] id;
		case ($urandom_range(0, 3))
		0:       id = ID_RIFF ^ (32'd1 << $urandom_range(0, 31));
		1:       id = ID_FMT ^ (32'd1 << $urandom_range(0, 31));
		2:       id = ID_DATA ^ (32'd1 << $urandom_range(0, 31));
		default: id = $urandom;
		endcase
		while (id == ID_RIFF || id == ID_FMT || id == ID_DATA || id == ID_WAVE)
			id = $urandom;
		return id;
	endfunction

	function automatic logic [15:0] pick_channels();
		case ($urandom_range(0, 7))
		0, 1, 2: return CH_MONO;
		3, 4, 5: return 16'd2;
		6:       return 16'd0;
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_bits();
		case ($urandom_range(0, 7))
		0, 1, 2: return BITS_U8;
		3, 4, 5: return 16'd16;
		6:       return 16'd0;
		default: return 16'($urandom);
		endcase
	endfunction

	// Hold the sender until every expected word has come back.
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (parsed_events.size() != 0) @(posedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= REG_MAX_CHUNK;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Write the size limit while idle and read it back.
	task automatic set_size_limit(input logic [31:0] v);
		logic [31:0] rd;
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_xfer(1'b1, v, rd);
		apb_xfer(1'b0, 32'd0, rd);
		if (rd !== v) begin
			err_count++;
			$error("max_chunk_size: expected %0d, actual %0d", v, rd);
		end
		size_limit = v;
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_register();
		logic [31:0] rd;
		apb_xfer(1'b0, 32'd0, rd);
		if (rd !== MAX_CHUNK_RESET) begin
			err_count++;
			$error("max_chunk_size: expected %0d, actual %0d", MAX_CHUNK_RESET, rd);
		end
		set_size_limit(32'd0);
		set_size_limit(32'hFFFF_FFFF);
	endtask

	// WAVE header with an all-ones size, a non-WAVE RIFF shorter than its form,
	// a short fmt chunk, and an empty unknown chunk.
	task automatic test_directed_chunks();
		send_riff(ID_WAVE, 32'hFFFF_FFFF);
		send_riff(FORM_LIST, 32'd2);
		send_fmt(FMT_TAG_PCM, 16'd2, 32'd44100, 16'd16, 32'd4);
		send_other(stray_id(), 32'd0);
	endtask

	// Zero limit: empty chunks still skip, a long fmt tail is not limited.
	task automatic test_limit_zero();
		set_size_limit(32'd0);
		send_other(stray_id(), 32'd0);
		send_fmt(FMT_TAG_PCM, CH_MONO, 32'd8000, BITS_U8, 32'd24);
		send_riff(ID_WAVE, 32'd100);
	endtask

	// Well-formed chunks with random content, a few near-miss ids and limit changes.
	// The second quarter of the run goes without idling on either side.
	task automatic test_random_chunks(input int target);
		int pick;
		set_size_limit($urandom_range(8, 48));
		while (words_sent < target) begin
			stalls_on = !(words_sent >= target / 4 && words_sent < target / 2);
			pick = $urandom_range(0, 99);
			if (pick < 4)
				set_size_limit($urandom_range(0, 64));
			else if (pick < 40)
				send_other(stray_id(), $urandom_range(0, size_limit));
			else if (pick < 55)
				send_fmt(FMT_TAG_PCM, pick_channels(), $urandom, pick_bits(),
					$urandom_range(10, 28));
			else if (pick < 65)
				send_riff(ID_WAVE, $urandom);
			else if (pick < 75)
				send_riff(stray_id(), $urandom_range(0, size_limit));
			else if (pick < 88)
				send_other(stray_id(), size_limit);
			else
				send_other(stray_id(), 32'd0);
		end
		stalls_on = 1'b1;
	endtask

	// Data chunk: edge bytes first, a no-stall stretch, a drain pause midway,
	// and sometimes an empty chunk or a cut by end of file.
	task automatic test_data_chunk();
		logic [31:0] len;
		logic [31:0] cut;
		logic [7:0]  b;
		if ($urandom_range(0, 7) != 0)
			send_fmt(FMT_TAG_PCM, pick_channels(), $urandom, pick_bits(),
				$urandom_range(14, 20));
		len = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom_range(800, 1100);
		cut = ($urandom_range(0, 5) == 0 && len > 1) ? $urandom_range(1, len - 1) : len;
		ending_name = (len == 0) ? "empty data chunk" :
			(cut < len) ? "end of file inside data" : "data end";
		send_head(ID_DATA, len);
		for (int i = 0; i < cut; i++) begin
			if (i == 100)
				stalls_on = 1'b0;
			if (i == 400)
				stalls_on = 1'b1;
			if (i == cut / 2)
				hold_until_drained();
			case (i)
			0:       b = 8'h00;
			1:       b = 8'hFF;
			2:       b = 8'h80;
			3:       b = 8'h7F;
			4:       b = 8'h01;
			5:       b = 8'hFE;
			default: b = 8'($urandom);
			endcase
			send_word(KIND_BYTE, b);
		end
		stalls_on = 1'b1;
		if (cut < len)
			send_eof();
	endtask

	task automatic test_stream_end(input int pick);
		logic [15:0] tag;
		logic [31:0] len;
		if (pick < 6) begin
			ending_name = "unsupported format";
			case ($urandom_range(0, 3))
			0:       tag = 16'h0000;
			1:       tag = 16'hFFFF;
			2:       tag = 16'hFFFE;
			default: tag = 16'($urandom_range(2, 65535));
			endcase
			send_fmt(tag, pick_channels(), $urandom, pick_bits(), $urandom_range(10, 24));
		end else if (pick < 12) begin
			ending_name = "chunk too large";
			len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : size_limit + 1 + $urandom_range(0, 1000);
			if ($urandom_range(0, 1)) begin
				send_head(stray_id(), len);
			end else begin
				send_head(ID_RIFF, len);
				send_u32(stray_id());
			end
		end else if (pick < 18) begin
			ending_name = "end of file outside data";
			case ($urandom_range(0, 2))
			0: repeat ($urandom_range(1, 7)) send_word(KIND_BYTE, 8'($urandom));
			1: begin
				send_head(ID_FMT, 32'd16);
				repeat ($urandom_range(0, 15)) send_word(KIND_BYTE, 8'($urandom));
			end
			default: begin
				send_head(stray_id(), size_limit);
				repeat ($urandom_range(0, size_limit > 0 ? size_limit - 1 : 0))
					send_word(KIND_BYTE, 8'($urandom));
			end
			endcase
			send_eof();
		end else begin
			test_data_chunk();
		end
	endtask

	// Once stopped or halted, the block must ignore bytes and end of file.
	task automatic test_ignored_tail();
		send_fill(5);
		send_eof();
		send_fill(2);
		while (words_sent < ITEM_TARGET)
			send_fill(32'd1);
	endtask

	// ---------------------------------------------------------------- run

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("wav_stream_parser verification failed");
		$finish;
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = KIND_BYTE;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = REG_MAX_CHUNK;
		pwdata   = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		ending_pick = $urandom_range(0, 99);
		test_register();
		test_directed_chunks();
		test_limit_zero();
		test_random_chunks(ending_pick < 18 ? 1600 : 650);
		test_stream_end(ending_pick);
		test_ignored_tail();
		hold_until_drained();
		repeat (8) @(posedge clk);
		$display("Covered %0d input words, %0d result words checked, %0d of them frames.",
			words_sent, results_checked, frames_checked);
		$display("Stream ended by: %s; size limit went through reset, zero, all ones, random.",
			ending_name);
		if (err_count == 0)
			$display("wav_stream_parser verification clean");
		else
			$display("wav_stream_parser verification failed");
		$finish;
	end

endmodule
